// ===== rtl/erp_pkg.sv =====
// Package for the Euclidean rhythm pattern block.
// Port field widths shared by the top level; no dependencies.
`default_nettype none

package erp_pkg;

  localparam int IN_W  = 7;   // steps / pulses request fields
  localparam int PAT_W = 64;  // onset pattern field
  localparam int LEN_W = 7;   // effective length field

endpackage

`default_nettype wire

// ===== rtl/erp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module erp_ram #(
  parameter int Width = 1,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/euclidean_rhythm_pattern.sv =====
// Euclidean rhythm generator (Bjorklund grouping), top level.
// Depends on erp_pkg (field widths) and erp_ram (sequence buffers).
`default_nettype none

// Usage: raise start with steps_i / pulses_i while busy is low; the item is
// taken at that clock edge and busy rises. Both fields saturate at MAX_STEPS,
// and the length is raised to the pulse count when pulses exceed steps.
// The result (pattern_o, length_o) is shown for exactly one cycle with
// done_o high; the receiver cannot stall it, so it must capture it then.
// busy drops in that same cycle, so a new item may be started right away.
// Sequence: an item first seeds the sequence, then makes one regrouping
// pass per Bjorklund step (a loop check, a setup step, bit-by-bit copying
// with idle steps at group boundaries, and a step to close the pass), then
// a final loop check and a serial readout of the pattern. The single-bit
// read/write port pair of the ping-pong sequence buffers sets the pace.
module euclidean_rhythm_pattern
#(
  parameter int MAX_STEPS = 64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start,
  output      logic                       busy,
  input  wire logic [erp_pkg::IN_W-1:0]   steps_i,
  input  wire logic [erp_pkg::IN_W-1:0]   pulses_i,
  output      logic                       done_o,
  output      logic [erp_pkg::PAT_W-1:0]  pattern_o,
  output      logic [erp_pkg::LEN_W-1:0]  length_o
);

  import erp_pkg::*;

  localparam int CW = $clog2(MAX_STEPS + 1);  // counts 0..MAX_STEPS
  localparam int AW = $clog2(MAX_STEPS);      // buffer address
  localparam int PW = 2 * CW;                 // group-count * group-size

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,   // seed k onsets then rests
    ST_CHECK,  // loop test, form leading-region end
    ST_BOUND,  // guard on leading-region end, set up pass
    ST_PASS,   // interleave one bit per cycle, except at group boundaries, into the other buffer
    ST_READ    // serial readout into the pattern register
  } state_e;

  state_e          state_q, state_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic            cur_q, cur_d;        // which buffer holds the sequence
  logic [CW-1:0]   n_q, n_d, k_q, k_d;
  logic [CW-1:0]   lead_cnt_q, lead_cnt_d, rem_cnt_q, rem_cnt_d;
  logic [CW-1:0]   lead_sz_q, lead_sz_d, rem_sz_q, rem_sz_d;
  logic [PW-1:0]   lead_end_q, lead_end_d;
  logic [CW-1:0]   li_q, li_d, ri_q, ri_d, t_q, t_d, j_q, j_d;
  logic            rem_ph_q, rem_ph_d;  // 0: leading group, 1: remainder group
  logic            pend_q, pend_d;      // copy write due next cycle
  logic [AW-1:0]   waddr_q, waddr_d;
  logic [CW-1:0]   ic_q, ic_d;          // readout issue index
  logic            sv_q, sv_d;          // readout shift due
  logic            bv_q, bv_d;          // shifted bit is inside the length
  logic [MAX_STEPS-1:0] pat_q, pat_d;
  logic [PAT_W-1:0] pattern_q, pattern_d;
  logic [LEN_W-1:0] length_q, length_d;

  // Request saturation and length raise
  logic [CW-1:0] sat_n, sat_k;
  assign sat_n = (steps_i  > IN_W'(MAX_STEPS)) ? CW'(MAX_STEPS) : steps_i[CW-1:0];
  assign sat_k = (pulses_i > IN_W'(MAX_STEPS)) ? CW'(MAX_STEPS) : pulses_i[CW-1:0];

  // Buffer ports
  logic          rd_bit;
  logic [1:0]    rdata;
  logic [AW-1:0] raddr;
  logic          wr_en, wr_bit, wr_sel;
  logic [AW-1:0] wr_addr;
  logic          init_we;

  assign rd_bit  = cur_q ? rdata[1] : rdata[0];
  assign init_we = (state_q == ST_INIT) && (t_q != n_q);
  assign wr_en   = init_we || pend_q;
  assign wr_addr = init_we ? t_q[AW-1:0] : waddr_q;
  assign wr_bit  = init_we ? (t_q < k_q) : rd_bit;
  // seeding writes the current buffer, copies go to the other one
  assign wr_sel  = init_we ? cur_q : ~cur_q;

  for (genvar b = 0; b < 2; b++) begin : g_buf
    erp_ram #(
      .Width (1),
      .Depth (MAX_STEPS)
    ) u_buf (
      .clk_i   (clk_i),
      .we_i    (wr_en && (wr_sel == 1'(b))),
      .waddr_i (wr_addr),
      .wdata_i (wr_bit),
      .raddr_i (raddr),
      .rdata_o (rdata[b])
    );
  end

  always_comb begin
    state_d    = state_q;
    busy_d     = busy_q;
    done_d     = 1'b0;
    cur_d      = cur_q;
    n_d        = n_q;
    k_d        = k_q;
    lead_cnt_d = lead_cnt_q;
    rem_cnt_d  = rem_cnt_q;
    lead_sz_d  = lead_sz_q;
    rem_sz_d   = rem_sz_q;
    lead_end_d = lead_end_q;
    li_d       = li_q;
    ri_d       = ri_q;
    t_d        = t_q;
    j_d        = j_q;
    rem_ph_d   = rem_ph_q;
    pend_d     = 1'b0;
    waddr_d    = waddr_q;
    ic_d       = ic_q;
    sv_d       = 1'b0;
    bv_d       = bv_q;
    pat_d      = pat_q;
    pattern_d  = pattern_q;
    length_d   = length_q;
    raddr      = '0;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          n_d        = (sat_k > sat_n) ? sat_k : sat_n;
          k_d        = sat_k;
          lead_cnt_d = sat_k;
          rem_cnt_d  = ((sat_k > sat_n) ? sat_k : sat_n) - sat_k;
          lead_sz_d  = CW'(1);
          rem_sz_d   = CW'(1);
          t_d        = '0;
          busy_d     = 1'b1;
          state_d    = ST_INIT;
        end
      end

      ST_INIT: begin
        if (t_q == n_q) begin
          state_d = ST_CHECK;
        end else begin
          t_d = t_q + CW'(1);
        end
      end

      ST_CHECK: begin
        if ((lead_cnt_q > CW'(1)) && (rem_cnt_q > CW'(1))) begin
          lead_end_d = PW'(lead_cnt_q) * PW'(lead_sz_q);
          state_d    = ST_BOUND;
        end else begin
          ic_d    = '0;
          state_d = ST_READ;
        end
      end

      ST_BOUND: begin
        if (lead_end_q > PW'(n_q)) begin
          ic_d    = '0;
          state_d = ST_READ;
        end else begin
          li_d     = '0;
          ri_d     = lead_end_q[CW-1:0];
          t_d      = '0;
          j_d      = '0;
          rem_ph_d = 1'b0;
          state_d  = ST_PASS;
        end
      end

      ST_PASS: begin
        if (t_q == n_q) begin
          // pass complete: last pending copy lands this cycle
          cur_d = ~cur_q;
          if (rem_cnt_q >= lead_cnt_q) begin
            rem_cnt_d = rem_cnt_q - lead_cnt_q;
            lead_sz_d = lead_sz_q + rem_sz_q;
          end else begin
            lead_cnt_d = rem_cnt_q;
            rem_cnt_d  = lead_cnt_q - rem_cnt_q;
            lead_sz_d  = lead_sz_q + rem_sz_q;
            rem_sz_d   = lead_sz_q;
          end
          state_d = ST_CHECK;
        end else if (!rem_ph_q) begin
          if ((PW'(li_q) < lead_end_q) && (j_q < lead_sz_q)) begin
            raddr   = li_q[AW-1:0];
            pend_d  = 1'b1;
            waddr_d = t_q[AW-1:0];
            li_d    = li_q + CW'(1);
            t_d     = t_q + CW'(1);
            j_d     = j_q + CW'(1);
          end else begin
            rem_ph_d = 1'b1;
            j_d      = '0;
          end
        end else begin
          if ((ri_q < n_q) && (j_q < rem_sz_q)) begin
            raddr   = ri_q[AW-1:0];
            pend_d  = 1'b1;
            waddr_d = t_q[AW-1:0];
            ri_d    = ri_q + CW'(1);
            t_d     = t_q + CW'(1);
            j_d     = j_q + CW'(1);
          end else begin
            rem_ph_d = 1'b0;
            j_d      = '0;
          end
        end
      end

      ST_READ: begin
        if (ic_q != CW'(MAX_STEPS)) begin
          raddr = ic_q[AW-1:0];
          sv_d  = 1'b1;
          bv_d  = (ic_q < n_q);
          ic_d  = ic_q + CW'(1);
        end
        if (sv_q) begin
          pat_d = {bv_q & rd_bit, pat_q[MAX_STEPS-1:1]};
        end
        if ((ic_q == CW'(MAX_STEPS)) && !sv_q) begin
          pattern_d = PAT_W'(pat_q);
          length_d  = LEN_W'(n_q);
          done_d    = 1'b1;
          busy_d    = 1'b0;
          state_d   = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cur_q   <= 1'b0;
      pend_q  <= 1'b0;
      sv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      sv_q    <= sv_d;
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    k_q        <= k_d;
    lead_cnt_q <= lead_cnt_d;
    rem_cnt_q  <= rem_cnt_d;
    lead_sz_q  <= lead_sz_d;
    rem_sz_q   <= rem_sz_d;
    lead_end_q <= lead_end_d;
    li_q       <= li_d;
    ri_q       <= ri_d;
    t_q        <= t_d;
    j_q        <= j_d;
    rem_ph_q   <= rem_ph_d;
    waddr_q    <= waddr_d;
    ic_q       <= ic_d;
    bv_q       <= bv_d;
    pat_q      <= pat_d;
    pattern_q  <= pattern_d;
    length_q   <= length_d;
  end

  assign busy      = busy_q;
  assign done_o    = done_q;
  assign pattern_o = pattern_q;
  assign length_o  = length_q;

endmodule

`default_nettype wire
